@@ hdl/assert_macros.svh @@
// Assertion macros shared by the integer-to-text RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under the block clock, off during reset.
`define ITR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("itr assertion failed");

// Antecedent implies consequent in the next cycle.
`define ITR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itr assertion failed");

`endif

@@ hdl/itr_pkg.sv @@
// Package for the integer-to-text radix converter: widths, state codes,
// divider status struct and the digit-to-ASCII function. No dependencies.
`timescale 1ns / 1ps

package itr_pkg;

  localparam int ValueWidth = 64;
  localparam int BaseWidth  = 6;
  localparam int StepCntW   = $clog2(ValueWidth);
  localparam int DigitDepth = ValueWidth;            // base 2 worst case
  localparam int DigitIdxW  = $clog2(DigitDepth);
  localparam int DigitCntW  = DigitIdxW + 1;

  localparam logic [BaseWidth-1:0] BaseMin = BaseWidth'(2);
  localparam logic [BaseWidth-1:0] BaseMax = BaseWidth'(36);
  localparam logic [BaseWidth-1:0] BaseTen = BaseWidth'(10);

  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharA     = 8'h61;  // 'a'
  localparam logic [7:0] CharMinus = 8'h2d;  // '-'
  localparam logic [7:0] CharNul   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_WAIT,
    ST_MINUS,
    ST_READ,
    ST_EMIT
  } itr_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [7:0] digit_char(input logic [BaseWidth-1:0] d);
    logic [7:0] d8;
    d8 = {{(8-BaseWidth){1'b0}}, d};
    if (d < BaseTen) digit_char = CharZero + d8;
    else digit_char = CharA + (d8 - 8'd10);
  endfunction

endpackage

@@ hdl/itr_div.sv @@
// Bit-serial restoring divider: value by a small base, one quotient bit a cycle.
// Depends on itr_pkg.
`timescale 1ns / 1ps

module itr_div import itr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] dividend_i,
  input  logic [BaseWidth-1:0]  base_i,
  output logic [ValueWidth-1:0] quotient_o,
  output logic [BaseWidth-1:0]  remainder_o,
  output div_status_t           status_o
);

  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [BaseWidth-1:0]  rem_q, rem_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [BaseWidth:0]    trial;
  logic [BaseWidth:0]    diff;
  logic                  qbit;

  // remainder stays below base, so the trial fits one extra bit
  assign trial = {rem_q, acc_q[ValueWidth-1]};
  assign diff  = trial - {1'b0, base_i};
  assign qbit  = (trial >= {1'b0, base_i});

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[ValueWidth-2:0], qbit};
      rem_d = qbit ? diff[BaseWidth-1:0] : trial[BaseWidth-1:0];
      cnt_d = cnt_q + StepCntW'(1);
      if (cnt_q == StepCntW'(ValueWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign quotient_o    = acc_q;
  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ hdl/integer_to_text_radix_top.sv @@
// Top level of the integer-to-text radix converter: sequencer, digit store
// and output register. Depends on itr_pkg, itr_div and assert_macros.svh.
//
//  channel  | dir | tdata (low bit up)          | tuser       | tlast
//  s_axis   | in  | value[63:0], base[69:64]    | kind        | -
//  m_axis   | out | character[7:0]              | error       | last
//
// Each digit costs one pass of the bit-serial divider plus a handoff; a minus
// sign adds the ST_MINUS state to the word, and a bad base goes straight to a
// single error character. Each digit leaves by way of ST_READ (registered digit
// store read) and then ST_EMIT.
// s_axis_tready_o is high only while the sequencer is idle; the output
// register holds its word until m_axis_tready_i, and the sequencer waits.
// Reset clears control state only; the digit store is written before read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_to_text_radix_top import itr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // value[63:0], base[69:64], zero pad
  input  logic [0:0]  s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // character[7:0]
  output logic [0:0]  m_axis_tuser_o,   // error
  output logic        m_axis_tlast_o
);

  itr_state_e state_q, state_d;

  // input unpack
  logic                  in_kind;
  logic [ValueWidth-1:0] in_value;
  logic [BaseWidth-1:0]  in_base;
  logic                  in_accept;
  logic                  in_base_ok;
  logic                  in_minus;
  logic [ValueWidth-1:0] in_mag;

  assign in_kind    = s_axis_tuser_i[0];
  assign in_value   = s_axis_tdata_i[ValueWidth-1:0];
  assign in_base    = s_axis_tdata_i[ValueWidth +: BaseWidth];
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_base_ok = in_base inside {[BaseMin:BaseMax]};
  assign in_minus   = in_kind && (in_base == BaseTen) && in_value[ValueWidth-1];
  assign in_mag     = in_minus ? (~in_value + ValueWidth'(1)) : in_value;

  // held job state
  logic [BaseWidth-1:0]  base_q;
  logic                  minus_q;
  logic [DigitCntW-1:0]  cnt_q;
  logic [DigitIdxW-1:0]  ptr_q;
  logic [BaseWidth-1:0]  rd_q;

  // digit store, least significant digit first
  logic [BaseWidth-1:0]  mem [DigitDepth];

  // divider
  logic                  div_start;
  logic [ValueWidth-1:0] div_operand;
  logic [ValueWidth-1:0] div_quot;
  logic [BaseWidth-1:0]  div_rem;
  div_status_t           div_st;
  logic [BaseWidth-1:0]  div_base;

  // output register
  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  out_last_q;
  logic                  out_err_q;
  logic                  out_free;

  // strobes
  logic                  job_load;
  logic                  mem_we;
  logic                  mem_re;
  logic                  out_load;
  logic [7:0]            out_char;
  logic                  out_last;
  logic                  out_err;
  logic                  ptr_dec;
  logic                  quot_zero;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign quot_zero = (div_quot == '0);
  assign div_base  = job_load ? in_base : base_q;

  itr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_operand),
    .base_i      (div_base),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .status_o    (div_st)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = in_base_ok ? ST_WAIT : ST_ERR;
      end
      ST_ERR: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_WAIT: begin
        if (div_st.done && quot_zero) state_d = minus_q ? ST_MINUS : ST_READ;
      end
      ST_MINUS: begin
        if (out_free) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = (ptr_q == '0) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    job_load        = 1'b0;
    div_start       = 1'b0;
    div_operand     = div_quot;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    out_load        = 1'b0;
    out_char        = CharNul;
    out_last        = 1'b0;
    out_err         = 1'b0;
    ptr_dec         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_accept) begin
          job_load    = 1'b1;
          div_start   = in_base_ok;
          div_operand = in_mag;
        end
      end
      ST_ERR: begin
        out_load = out_free;
        out_char = CharNul;
        out_last = 1'b1;
        out_err  = 1'b1;
      end
      ST_WAIT: begin
        if (div_st.done) begin
          mem_we    = 1'b1;
          div_start = !quot_zero;   // next digit from the quotient
        end
      end
      ST_MINUS: begin
        out_load = out_free;
        out_char = CharMinus;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_EMIT: begin
        out_load = out_free;
        out_char = digit_char(rd_q);
        out_last = (ptr_q == '0);
        ptr_dec  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_load && in_base_ok) begin
        cnt_q   <= '0;
        minus_q <= in_minus;
      end else if (mem_we) begin
        cnt_q <= cnt_q + DigitCntW'(1);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (job_load) base_q <= in_base;
    // on the final digit the old count is the top index
    if (mem_we) ptr_q <= cnt_q[DigitIdxW-1:0];
    else if (ptr_dec) ptr_q <= ptr_q - DigitIdxW'(1);
    if (out_load) begin
      out_char_q <= out_char;
      out_last_q <= out_last;
      out_err_q  <= out_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cnt_q[DigitIdxW-1:0]] <= div_rem;
    if (mem_re) rd_q <= mem[ptr_q];
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_char_q;
  assign m_axis_tuser_o[0] = out_err_q;
  assign m_axis_tlast_o    = out_last_q;

  `ITR_ASSERT(a_start_when_free, div_start |-> !div_st.busy)
  `ITR_ASSERT(a_cnt_in_range, cnt_q <= DigitCntW'(DigitDepth))
  `ITR_ASSERT(a_wait_has_div, (state_q == ST_WAIT) |-> (div_st.busy || div_st.done))
  `ITR_ASSERT_NEXT(a_last_to_idle, out_load && out_last, state_q == ST_IDLE)

endmodule
